// ===== design/rsmp_pkg.sv =====
// Shared constants and control types for the polyline resampler.
// Used by rsmp_outq and the top level; depends on nothing.
`timescale 1ns / 1ps

package rsmp_pkg;

	localparam int DEF_COORD_W     = 16;
	localparam int DEF_MAX_PER_SEG = 16;
	localparam int RESULT_LIMIT    = 33;
	localparam int RESULT_CNT_W    = $clog2(RESULT_LIMIT + 1);
	localparam int SPACING_W       = 12;
	localparam logic [SPACING_W-1:0] SPACING_RESET = 12'd320;

	localparam int CFG_ADDR_W = 2;
	localparam logic [CFG_ADDR_W-1:0] REG_SPACING  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_CENTER_X = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Y = 2'd2;

	// Requests from the sequencer to the result queue.
	typedef struct packed {
		logic push;
		logic finish;
		logic trunc;
	} oq_ctl_t;

	// Status from the result queue back to the sequencer.
	typedef struct packed {
		logic push_ok;
		logic fin_ok;
		logic pend_v;
	} oq_sts_t;

endpackage

// ===== design/rsmp_muldiv.sv =====
// Serial unsigned multiply (one bit per cycle) optionally followed by a
// restoring divide (one quotient bit per cycle). Uses no package items.
`timescale 1ns / 1ps

module rsmp_muldiv #(
	parameter int W = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic             div_en,
	input  logic [W-1:0]     a,
	input  logic [W-1:0]     b,
	input  logic [W-1:0]     d,
	output logic             done,
	output logic [2*W-1:0]   quo,
	output logic [W-1:0]     rem
);

	localparam int CNT_W = $clog2(2 * W + 1);

	typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV} mstate_t;

	mstate_t          state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic             div_en_q;
	logic [2*W-1:0]   acc_q;
	logic [W-1:0]     mplr_q;
	logic [W-1:0]     mcand_q;
	logic [W-1:0]     dvsr_q;
	logic [W-1:0]     rem_q;

	logic [W:0] r_next;
	logic [W:0] diff;
	logic       take;

	assign r_next = {rem_q, acc_q[2*W-1]};
	assign take   = r_next >= {1'b0, dvsr_q};
	assign diff   = r_next - {1'b0, dvsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (go) begin
						acc_q    <= '0;
						mplr_q   <= b;
						mcand_q  <= a;
						dvsr_q   <= d;
						div_en_q <= div_en;
						rem_q    <= '0;
						cnt_q    <= CNT_W'(W);
						state_q  <= M_MUL;
					end
				end
				M_MUL: begin
					acc_q  <= {acc_q[2*W-2:0], 1'b0}
						+ (mplr_q[W-1] ? {{W{1'b0}}, mcand_q} : {(2*W){1'b0}});
					mplr_q <= {mplr_q[W-2:0], 1'b0};
					cnt_q  <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						if (div_en_q) begin
							cnt_q   <= CNT_W'(2 * W);
							state_q <= M_DIV;
						end else begin
							done_q  <= 1'b1;
							state_q <= M_IDLE;
						end
					end
				end
				M_DIV: begin
					rem_q <= take ? diff[W-1:0] : r_next[W-1:0];
					acc_q <= {acc_q[2*W-2:0], take};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						done_q  <= 1'b1;
						state_q <= M_IDLE;
					end
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign quo  = acc_q;
	assign rem  = rem_q;

endmodule

// ===== design/rsmp_isqrt.sv =====
// Truncating integer square root, one root bit per cycle.
// Uses no package items.
`timescale 1ns / 1ps

module rsmp_isqrt #(
	parameter int W = 17
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           go,
	input  logic [2*W-1:0] v,
	output logic           done,
	output logic [W-1:0]   root
);

	localparam int CNT_W = $clog2(W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [2*W-1:0]   val_q;
	logic [W:0]       rem_q;
	logic [W-1:0]     root_q;

	logic [W+2:0] r2;
	logic [W+2:0] trial;
	logic [W+2:0] diff;
	logic         ge;

	assign r2    = {rem_q, val_q[2*W-1:2*W-2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = r2 >= trial;
	assign diff  = r2 - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (go) begin
					val_q  <= v;
					rem_q  <= '0;
					root_q <= '0;
					cnt_q  <= CNT_W'(W);
					busy_q <= 1'b1;
				end
			end else begin
				rem_q  <= ge ? diff[W:0] : r2[W:0];
				root_q <= {root_q[W-2:0], ge};
				val_q  <= {val_q[2*W-3:0], 2'b00};
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== design/rsmp_outq.sv =====
// Result queue: one held sample, used to mark the last result of a vertex and
// to apply the per-vertex result limit, then the output register.
// Depends on rsmp_pkg.
`timescale 1ns / 1ps

module rsmp_outq #(
	parameter int CW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rsmp_pkg::oq_ctl_t    ctl,
	input  logic signed [CW+1:0] px,
	input  logic signed [CW+1:0] py,
	input  logic signed [CW-1:0] cx,
	input  logic signed [CW-1:0] cy,
	output rsmp_pkg::oq_sts_t    sts,
	output logic                 m_valid,
	input  logic                 m_ready,
	output logic [CW-1:0]        m_x,
	output logic [CW-1:0]        m_y,
	output logic                 m_last,
	output logic                 m_trunc
);

	function automatic logic [CW-1:0] sat_sub(logic signed [CW+1:0] p,
		logic signed [CW-1:0] c);
		logic signed [CW+2:0] s;
		s = {p[CW+1], p} - {{3{c[CW-1]}}, c};
		if (s[CW+2:CW-1] == {4{1'b0}} || s[CW+2:CW-1] == {4{1'b1}})
			return s[CW-1:0];
		else if (s[CW+2])
			return {1'b1, {(CW-1){1'b0}}};
		else
			return {1'b0, {(CW-1){1'b1}}};
	endfunction

	logic [CW-1:0]                     pend_x_q, pend_y_q;
	logic                              pend_t_q;
	logic                              pend_v_q;
	logic [rsmp_pkg::RESULT_CNT_W-1:0] n_q;
	logic [CW-1:0]                     out_x_q, out_y_q;
	logic                              out_l_q, out_t_q;
	logic                              out_v_q;

	logic out_free;
	logic at_limit;

	assign out_free    = !out_v_q || m_ready;
	assign at_limit    = n_q >= rsmp_pkg::RESULT_CNT_W'(rsmp_pkg::RESULT_LIMIT);
	assign sts.push_ok = !pend_v_q || at_limit || out_free;
	assign sts.fin_ok  = !pend_v_q || out_free;
	assign sts.pend_v  = pend_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
			n_q      <= '0;
		end else begin
			if (out_v_q && m_ready)
				out_v_q <= 1'b0;
			if (ctl.push && sts.push_ok) begin
				if (!pend_v_q) begin
					pend_x_q <= sat_sub(px, cx);
					pend_y_q <= sat_sub(py, cy);
					pend_t_q <= ctl.trunc;
					pend_v_q <= 1'b1;
					n_q      <= rsmp_pkg::RESULT_CNT_W'(1);
				end else if (!at_limit) begin
					out_x_q  <= pend_x_q;
					out_y_q  <= pend_y_q;
					out_t_q  <= pend_t_q;
					out_l_q  <= 1'b0;
					out_v_q  <= 1'b1;
					pend_x_q <= sat_sub(px, cx);
					pend_y_q <= sat_sub(py, cy);
					pend_t_q <= ctl.trunc;
					n_q      <= n_q + 1'b1;
				end else begin
					// Past the limit the sample is dropped and the held one flagged.
					pend_t_q <= 1'b1;
				end
			end else if (ctl.finish && sts.fin_ok) begin
				if (pend_v_q) begin
					out_x_q  <= pend_x_q;
					out_y_q  <= pend_y_q;
					out_t_q  <= pend_t_q;
					out_l_q  <= 1'b1;
					out_v_q  <= 1'b1;
					pend_v_q <= 1'b0;
				end
				n_q <= '0;
			end
		end
	end

	assign m_valid = out_v_q;
	assign m_x     = out_x_q;
	assign m_y     = out_y_q;
	assign m_last  = out_l_q;
	assign m_trunc = out_t_q;

endmodule

// ===== design/polyline_equal_spacing_resampler.sv =====
// Equal arc length resampler: top level with the per-vertex sequencer.
// Depends on rsmp_pkg, rsmp_muldiv, rsmp_isqrt and rsmp_outq.
`timescale 1ns / 1ps

// One vertex is taken at a time; s_axis_tready is high only while the block
// is idle. Each segment first computes the squares, root and sample count,
// then scales both coordinates of each emitted sample; the arithmetic is W =
// COORD_WIDTH + 1 bits wide. The squares, count and scaling share one
// bit-serial multiply and divide unit; the root has its own unit.
// Results leave through an output register, so the last result of one vertex
// may still wait on m_axis_tready while the next vertex is being worked.

module polyline_equal_spacing_resampler #(
	parameter int COORD_WIDTH     = rsmp_pkg::DEF_COORD_W,
	parameter int MAX_PER_SEGMENT = rsmp_pkg::DEF_MAX_PER_SEG,
	localparam int TDATA_W        = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [TDATA_W-1:0]              s_axis_tdata,  // point_x, point_y
	input  logic [1:0]                      s_axis_tuser,  // starts_subpath, closes_subpath
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [TDATA_W-1:0]              m_axis_tdata,  // sample_x, sample_y
	output logic                            m_axis_tlast,  // last_of_run
	output logic [0:0]                      m_axis_tuser,  // truncated
	input  logic                            cfg_we,
	input  logic [rsmp_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [COORD_WIDTH-1:0]          cfg_data
);

	localparam int CW = COORD_WIDTH;
	localparam int W  = CW + 1;
	localparam int EW = $clog2(MAX_PER_SEGMENT + 1);
	localparam int SW = rsmp_pkg::SPACING_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_START, ST_SEG, ST_SQX, ST_SQY, ST_ROOT, ST_PLAN,
		ST_COUNT, ST_SCX, ST_SCY, ST_EMIT, ST_SEGEND, ST_FIN
	} state_t;

	state_t state_q;

	logic [SW-1:0]        spacing_q;
	logic signed [CW-1:0] cx_q, cy_q;
	logic signed [CW-1:0] prev_x_q, prev_y_q, org_x_q, org_y_q, tgt_x_q, tgt_y_q;
	logic [W-1:0]         carry_q;
	logic                 close_q;
	logic                 negx_q, negy_q;
	logic [W-1:0]         mx_q, my_q, len_q, pos_q, sx_q, sy_q;
	logic [2*W-1:0]       sq_q;
	logic [EW-1:0]        k_q, emit_q;
	logic                 trunc_q;

	logic                 md_go_q, md_div_q;
	logic [W-1:0]         md_a_q, md_b_q, md_d_q;
	logic                 md_done;
	logic [2*W-1:0]       md_quo;
	logic [W-1:0]         md_rem;
	logic                 sq_go_q;
	logic                 sq_done;
	logic [W-1:0]         sq_root;

	rsmp_pkg::oq_ctl_t    oq_ctl;
	rsmp_pkg::oq_sts_t    oq_sts;
	logic signed [CW+1:0] push_x, push_y;
	logic [CW-1:0]        res_x, res_y;

	// Segment setup
	logic signed [W-1:0] dx, dy;
	logic [W-1:0]        adx, ady;
	logic [SW-1:0]       sp_eff;
	logic [W-1:0]        carry_cl;
	logic [W-1:0]        first;
	logic [W-1:0]        pos_nx;

	assign dx     = {tgt_x_q[CW-1], tgt_x_q} - {prev_x_q[CW-1], prev_x_q};
	assign dy     = {tgt_y_q[CW-1], tgt_y_q} - {prev_y_q[CW-1], prev_y_q};
	assign adx    = dx[W-1] ? W'(-dx) : W'(dx);
	assign ady    = dy[W-1] ? W'(-dy) : W'(dy);
	assign sp_eff = (spacing_q == '0) ? SW'(1) : spacing_q;
	assign carry_cl = (carry_q < W'(sp_eff)) ? carry_q : W'(sp_eff);
	assign first  = W'(sp_eff) - carry_cl;
	assign pos_nx = pos_q + W'(sp_eff);

	always_comb begin
		if (state_q == ST_START) begin
			push_x = {{2{prev_x_q[CW-1]}}, prev_x_q};
			push_y = {{2{prev_y_q[CW-1]}}, prev_y_q};
		end else begin
			push_x = {{2{prev_x_q[CW-1]}}, prev_x_q}
				+ (negx_q ? -{1'b0, sx_q} : {1'b0, sx_q});
			push_y = {{2{prev_y_q[CW-1]}}, prev_y_q}
				+ (negy_q ? -{1'b0, sy_q} : {1'b0, sy_q});
		end
		oq_ctl.push   = (state_q == ST_START) || (state_q == ST_EMIT);
		oq_ctl.finish = (state_q == ST_FIN);
		oq_ctl.trunc  = (state_q == ST_EMIT) && trunc_q;
	end

	assign s_axis_tready = (state_q == ST_IDLE);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= rsmp_pkg::SPACING_RESET;
			cx_q      <= '0;
			cy_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				rsmp_pkg::REG_SPACING:  spacing_q <= cfg_data[SW-1:0];
				rsmp_pkg::REG_CENTER_X: cx_q      <= cfg_data;
				rsmp_pkg::REG_CENTER_Y: cy_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			prev_x_q <= '0;
			prev_y_q <= '0;
			org_x_q  <= '0;
			org_y_q  <= '0;
			carry_q  <= '0;
			close_q  <= 1'b0;
			md_go_q  <= 1'b0;
			sq_go_q  <= 1'b0;
			k_q      <= '0;
			emit_q   <= '0;
		end else begin
			md_go_q <= 1'b0;
			sq_go_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						close_q <= s_axis_tuser[1];
						tgt_x_q <= s_axis_tdata[CW-1:0];
						tgt_y_q <= s_axis_tdata[2*CW-1:CW];
						if (s_axis_tuser[0]) begin
							prev_x_q <= s_axis_tdata[CW-1:0];
							prev_y_q <= s_axis_tdata[2*CW-1:CW];
							org_x_q  <= s_axis_tdata[CW-1:0];
							org_y_q  <= s_axis_tdata[2*CW-1:CW];
							carry_q  <= '0;
							state_q  <= ST_START;
						end else begin
							state_q <= ST_SEG;
						end
					end
				end
				ST_START: begin
					if (oq_sts.push_ok) begin
						if (close_q) begin
							close_q <= 1'b0;
							tgt_x_q <= org_x_q;
							tgt_y_q <= org_y_q;
							state_q <= ST_SEG;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_SEG: begin
					negx_q   <= dx[W-1];
					negy_q   <= dy[W-1];
					mx_q     <= adx;
					my_q     <= ady;
					md_a_q   <= adx;
					md_b_q   <= adx;
					md_div_q <= 1'b0;
					md_go_q  <= 1'b1;
					state_q  <= ST_SQX;
				end
				ST_SQX: begin
					if (md_done) begin
						sq_q    <= md_quo;
						md_a_q  <= my_q;
						md_b_q  <= my_q;
						md_go_q <= 1'b1;
						state_q <= ST_SQY;
					end
				end
				ST_SQY: begin
					if (md_done) begin
						sq_q    <= sq_q + md_quo;
						sq_go_q <= 1'b1;
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (sq_done) begin
						len_q   <= sq_root;
						state_q <= (sq_root == '0) ? ST_SEGEND : ST_PLAN;
					end
				end
				ST_PLAN: begin
					if (first > len_q) begin
						carry_q <= carry_cl + len_q;
						state_q <= ST_SEGEND;
					end else begin
						pos_q    <= first;
						md_a_q   <= len_q - first;
						md_b_q   <= W'(1);
						md_d_q   <= W'(sp_eff);
						md_div_q <= 1'b1;
						md_go_q  <= 1'b1;
						state_q  <= ST_COUNT;
					end
				end
				ST_COUNT: begin
					if (md_done) begin
						// The remainder is the distance left after the last sample.
						carry_q <= md_rem;
						trunc_q <= md_quo >= (2*W)'(MAX_PER_SEGMENT);
						emit_q  <= (md_quo >= (2*W)'(MAX_PER_SEGMENT))
							? EW'(MAX_PER_SEGMENT) : EW'(md_quo + 1'b1);
						k_q     <= '0;
						md_a_q  <= mx_q;
						md_b_q  <= pos_q;
						md_d_q  <= len_q;
						md_go_q <= 1'b1;
						state_q <= ST_SCX;
					end
				end
				ST_SCX: begin
					if (md_done) begin
						sx_q    <= md_quo[W-1:0];
						md_a_q  <= my_q;
						md_go_q <= 1'b1;
						state_q <= ST_SCY;
					end
				end
				ST_SCY: begin
					if (md_done) begin
						sy_q    <= md_quo[W-1:0];
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (oq_sts.push_ok) begin
						k_q   <= k_q + 1'b1;
						pos_q <= pos_nx;
						if (k_q + 1'b1 == emit_q) begin
							state_q <= ST_SEGEND;
						end else begin
							md_a_q  <= mx_q;
							md_b_q  <= pos_nx;
							md_go_q <= 1'b1;
							state_q <= ST_SCX;
						end
					end
				end
				ST_SEGEND: begin
					prev_x_q <= tgt_x_q;
					prev_y_q <= tgt_y_q;
					if (close_q) begin
						close_q <= 1'b0;
						tgt_x_q <= org_x_q;
						tgt_y_q <= org_y_q;
						state_q <= ST_SEG;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (oq_sts.fin_ok)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	rsmp_muldiv #(.W(W)) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (md_go_q),
		.div_en (md_div_q),
		.a      (md_a_q),
		.b      (md_b_q),
		.d      (md_d_q),
		.done   (md_done),
		.quo    (md_quo),
		.rem    (md_rem)
	);

	rsmp_isqrt #(.W(W)) u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (sq_go_q),
		.v      (sq_q),
		.done   (sq_done),
		.root   (sq_root)
	);

	rsmp_outq #(.CW(CW)) u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (oq_ctl),
		.px      (push_x),
		.py      (push_y),
		.cx      (cx_q),
		.cy      (cy_q),
		.sts     (oq_sts),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.m_x     (res_x),
		.m_y     (res_y),
		.m_last  (m_axis_tlast),
		.m_trunc (m_axis_tuser[0])
	);

	assign m_axis_tdata = TDATA_W'({res_y, res_x});

	// A vertex is never left with a held result once the block is idle again.
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !oq_sts.pend_v)
		else $error("held result left over at end of vertex");

	// The carried distance always stays below 1 << SW, so it never exceeds the largest spacing.
	a_carry_range: assert property (@(posedge clk) disable iff (!arst_n)
		carry_q < W'(1 << SW))
		else $error("carried distance out of range");

	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> (k_q < emit_q && emit_q <= EW'(MAX_PER_SEGMENT)))
		else $error("sample index beyond emit count");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> state_q != ST_IDLE)
		else $error("accepted vertex not started");

endmodule

// ===== bench/tb_polyline_equal_spacing_resampler.sv =====
// Self-checking testbench for polyline_equal_spacing_resampler.
// Depends on rsmp_pkg and the resampler RTL; predicts every sample in place.
`timescale 1ns / 1ps

module tb_polyline_equal_spacing_resampler;

	localparam int CW = 16;
	localparam int MAXSEG = 16;
	localparam int CYCLE_LIMIT = 6000000;
	localparam int SETTLE_CYCLES = 600;

	typedef struct {
		logic signed [CW-1:0] sx;
		logic signed [CW-1:0] sy;
		logic                 last;
		logic                 trunc;
	} sample_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [31:0]      s_axis_tdata = '0;  // point_x, point_y
	logic [1:0]       s_axis_tuser = '0;  // starts_subpath, closes_subpath
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [31:0]      m_axis_tdata;       // sample_x, sample_y
	logic             m_axis_tlast;       // last_of_run
	logic [0:0]       m_axis_tuser;       // truncated
	logic             cfg_we = 1'b0;
	logic [rsmp_pkg::CFG_ADDR_W-1:0] cfg_addr = rsmp_pkg::REG_SPACING;
	logic [CW-1:0]    cfg_data = '0;

	polyline_equal_spacing_resampler dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Predictor state mirrors the block's registers.
	longint spacing_q, cen_x, cen_y, prev_x, prev_y, org_x, org_y;
	longint unsigned carry_q;
	sample_t pending_samples[$];
	sample_t vertex_samples[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	longint cycles = 0;

	function automatic logic signed [CW-1:0] saturate(longint v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return v[CW-1:0];
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned root, rem, trial;
		root = 0;
		rem = 0;
		for (int i = 31; i >= 0; i--) begin
			rem = (rem << 2) | ((v >> (2 * i)) & 3);
			trial = (root << 2) | 1;
			if (rem >= trial) begin
				rem -= trial;
				root = (root << 1) | 1;
			end else begin
				root = root << 1;
			end
		end
		return root;
	endfunction

	function automatic longint scale_delta(longint d, longint unsigned pos,
			longint unsigned len);
		longint unsigned m;
		m = ((d < 0 ? -d : d) * pos) / len;
		return d < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic void add_sample(longint x, longint y, logic trunc);
		sample_t s;
		if (vertex_samples.size() >= rsmp_pkg::RESULT_LIMIT) begin
			vertex_samples[rsmp_pkg::RESULT_LIMIT-1].trunc = 1'b1;
			return;
		end
		s.sx = saturate(x - cen_x);
		s.sy = saturate(y - cen_y);
		s.last = 1'b0;
		s.trunc = trunc;
		vertex_samples.push_back(s);
	endfunction

	function automatic void walk_segment(longint tx, longint ty);
		longint dx, dy;
		longint unsigned len, sp, cr, first, count, emit;
		dx = tx - prev_x;
		dy = ty - prev_y;
		len = int_sqrt(dx * dx + dy * dy);
		if (len > 0) begin
			sp = (spacing_q == 0) ? 1 : spacing_q;
			cr = (carry_q < sp) ? carry_q : sp;
			first = sp - cr;
			if (first > len) begin
				carry_q = cr + len;
			end else begin
				count = (len - first) / sp + 1;
				emit = (count < MAXSEG) ? count : MAXSEG;
				carry_q = len - (first + (count - 1) * sp);
				for (longint unsigned k = 0; k < emit; k++)
					add_sample(prev_x + scale_delta(dx, first + k * sp, len),
						prev_y + scale_delta(dy, first + k * sp, len), count > MAXSEG);
			end
		end
		prev_x = tx;
		prev_y = ty;
	endfunction

	function automatic void predict_vertex(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
			logic start, logic close);
		vertex_samples.delete();
		if (start) begin
			org_x = x;
			org_y = y;
			prev_x = x;
			prev_y = y;
			carry_q = 0;
			add_sample(x, y, 1'b0);
		end else begin
			walk_segment(x, y);
		end
		if (close)
			walk_segment(org_x, org_y);
		if (vertex_samples.size() > 0)
			vertex_samples[vertex_samples.size()-1].last = 1'b1;
		foreach (vertex_samples[i])
			pending_samples.push_back(vertex_samples[i]);
	endfunction

	// Receiver side: random stall and comparison against the oldest expected sample.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_samples.size() == 0) begin
				$error("unexpected sample x=%0d y=%0d", $signed(m_axis_tdata[15:0]),
					$signed(m_axis_tdata[31:16]));
				errors++;
			end else begin
				sample_t e;
				e = pending_samples.pop_front();
				if (m_axis_tdata[15:0] !== e.sx) begin
					$error("sample_x expected %0d got %0d", e.sx, $signed(m_axis_tdata[15:0]));
					errors++;
				end
				if (m_axis_tdata[31:16] !== e.sy) begin
					$error("sample_y expected %0d got %0d", e.sy, $signed(m_axis_tdata[31:16]));
					errors++;
				end
				if (m_axis_tlast !== e.last) begin
					$error("last_of_run expected %0b got %0b", e.last, m_axis_tlast);
					errors++;
				end
				if (m_axis_tuser[0] !== e.trunc) begin
					$error("truncated expected %0b got %0b", e.trunc, m_axis_tuser[0]);
					errors++;
				end
			end
		end
	end

	task automatic send_vertex(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
			logic start, logic close);
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {y, x};
		s_axis_tuser <= {close, start};
		do @(posedge clk); while (!s_axis_tready);
		predict_vertex(x, y, start, close);
	endtask

	// Lets the block go idle: all samples out, then time for a vertex with none.
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [rsmp_pkg::CFG_ADDR_W-1:0] idx, logic [CW-1:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			rsmp_pkg::REG_SPACING: spacing_q = val[rsmp_pkg::SPACING_W-1:0];
			rsmp_pkg::REG_CENTER_X: cen_x = $signed(val);
			rsmp_pkg::REG_CENTER_Y: cen_y = $signed(val);
			default: ;
		endcase
	endtask

	task automatic test_directed;
		// Before any start vertex the path begins at the origin.
		send_vertex(16'sd160, 16'sd0, 1'b0, 1'b0);
		send_vertex(16'sd800, 16'sd0, 1'b0, 1'b0);
		send_vertex(16'sd800, 16'sd0, 1'b0, 1'b0);
		send_vertex(16'sd800, -16'sd700, 1'b0, 1'b1);
		send_vertex(16'sd50, 16'sd60, 1'b1, 1'b1);
		// Corner to corner: far more samples than a segment may emit.
		send_vertex(-16'sd32768, -16'sd32768, 1'b1, 1'b0);
		send_vertex(16'sd32767, 16'sd32767, 1'b0, 1'b1);
		// Lowering the spacing under the carried distance.
		write_reg(rsmp_pkg::REG_SPACING, 16'd4095);
		send_vertex(16'sd0, 16'sd0, 1'b1, 1'b0);
		send_vertex(16'sd3000, 16'sd0, 1'b0, 1'b0);
		write_reg(rsmp_pkg::REG_SPACING, 16'd100);
		send_vertex(16'sd3050, 16'sd0, 1'b0, 1'b0);
		write_reg(rsmp_pkg::REG_SPACING, 16'hf000);
		send_vertex(16'sd3060, 16'sd5, 1'b0, 1'b0);
		send_vertex(-16'sd3000, 16'sd9000, 1'b0, 1'b1);
		// Centre at the extremes forces saturation both ways.
		write_reg(rsmp_pkg::REG_SPACING, 16'd4095);
		write_reg(rsmp_pkg::REG_CENTER_X, 16'h7fff);
		write_reg(rsmp_pkg::REG_CENTER_Y, 16'h8000);
		send_vertex(-16'sd32768, 16'sd32767, 1'b1, 1'b0);
		send_vertex(16'sd32767, -16'sd32768, 1'b0, 1'b0);
		send_vertex(16'sd100, 16'sd100, 1'b0, 1'b1);
		write_reg(rsmp_pkg::REG_CENTER_X, 16'h8000);
		write_reg(rsmp_pkg::REG_CENTER_Y, 16'h7fff);
		send_vertex(16'sd32767, -16'sd32768, 1'b1, 1'b0);
		send_vertex(-16'sd32768, 16'sd32767, 1'b0, 1'b1);
		drain();
	endtask

	task automatic test_random_paths(int n_items, int idle_pct, int stall_pct,
			logic [CW-1:0] spacing, logic [CW-1:0] cx, logic [CW-1:0] cy);
		int sent, reach, span;
		logic signed [CW-1:0] x, y;
		longint nx, ny;
		write_reg(rsmp_pkg::REG_SPACING, spacing);
		write_reg(rsmp_pkg::REG_CENTER_X, cx);
		write_reg(rsmp_pkg::REG_CENTER_Y, cy);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(9) == 0) begin
				// Noise: arbitrary coordinates and flags.
				send_vertex(CW'($urandom), CW'($urandom), 1'($urandom_range(1)),
					1'($urandom_range(1)));
				sent++;
			end else begin
				reach = $urandom_range(3);
				span = (reach == 0) ? 64 : (reach == 1) ? 1024 : (reach == 2) ? 4096 : 32767;
				x = CW'($urandom);
				y = CW'($urandom);
				send_vertex(x, y, 1'b1, $urandom_range(15) == 0);
				sent++;
				for (int v = $urandom_range(6, 1); v > 0 && sent < n_items; v--) begin
					nx = x + $signed($urandom_range(2 * span)) - span;
					ny = y + $signed($urandom_range(2 * span)) - span;
					x = (nx > 32767) ? 16'sh7fff : (nx < -32768) ? 16'sh8000 : nx[CW-1:0];
					y = (ny > 32767) ? 16'sh7fff : (ny < -32768) ? 16'sh8000 : ny[CW-1:0];
					send_vertex(x, y, 1'b0, v == 1 && $urandom_range(1));
					sent++;
				end
			end
		end
		drain();
	endtask

	initial begin
		spacing_q = rsmp_pkg::SPACING_RESET;
		cen_x = 0;
		cen_y = 0;
		prev_x = 0;
		prev_y = 0;
		org_x = 0;
		org_y = 0;
		carry_q = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_paths(100, 0, 0, 16'd320, 16'd0, 16'd0);
		test_random_paths(100, 57, 0, 16'd1, 16'h0123, 16'hfedc);
		test_random_paths(100, 0, 57, 16'd4095, CW'($urandom), CW'($urandom));
		test_random_paths(100, 36, 36, CW'($urandom_range(600, 20)), CW'($urandom),
			CW'($urandom));
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
